FILE: hdl/nbrexp_pkg.sv
// Shared types and constants for the neighbor expiry table.
// Used by every module of the block. No dependencies.
package nbrexp_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 8;
    localparam int IN_TIME_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_TIME_W = 32;
    localparam int COUNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

FILE: hdl/nbrexp_alu.sv
// Shared add/subtract unit of the neighbor expiry table.
// Depends on nbrexp_pkg. On subtract, carry high means a >= b.
module nbrexp_alu #(
    parameter int TIME_BITS = nbrexp_pkg::TIME_BITS_DEF
) (
    input  nbrexp_pkg::alu_op_t  op,
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output logic [TIME_BITS-1:0] res,
    output logic                 carry
);
    import nbrexp_pkg::*;

    logic [TIME_BITS-1:0] b_eff;
    logic [TIME_BITS:0]   full;

    assign b_eff = (op == ALU_SUB) ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_eff} + (TIME_BITS + 1)'(op == ALU_SUB);
    assign res   = full[TIME_BITS-1:0];
    assign carry = full[TIME_BITS];

endmodule

FILE: hdl/nbrexp_mem.sv
// Address and expiry storage of the neighbor expiry table.
// Depends on nbrexp_pkg. One write port, one read port with registered data.
module nbrexp_mem #(
    parameter int TABLE_DEPTH = nbrexp_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = nbrexp_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
    input  logic [nbrexp_pkg::ADDR_W-1:0]  wr_address,
    input  logic [TIME_BITS-1:0]           wr_expiry,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
    output logic [nbrexp_pkg::ADDR_W-1:0]  rd_address,
    output logic [TIME_BITS-1:0]           rd_expiry
);
    import nbrexp_pkg::*;

    logic [ADDR_W-1:0]    address_mem [TABLE_DEPTH];
    logic [TIME_BITS-1:0] expiry_mem  [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            address_mem[wr_idx] <= wr_address;
            expiry_mem[wr_idx]  <= wr_expiry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_address <= address_mem[rd_idx];
        rd_expiry  <= expiry_mem[rd_idx];
    end

endmodule

FILE: hdl/nbrexp_ctrl.sv
// Sequencer of the neighbor expiry table: valid bits, entry scan and result register.
// Depends on nbrexp_pkg; drives nbrexp_alu and nbrexp_mem.
module nbrexp_ctrl #(
    parameter int TABLE_DEPTH = nbrexp_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = nbrexp_pkg::TIME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [nbrexp_pkg::OP_W-1:0]        operation,
    input  logic [nbrexp_pkg::ADDR_W-1:0]      neighbor_address,
    input  logic [nbrexp_pkg::IN_TIME_W-1:0]   lifetime,
    input  logic [nbrexp_pkg::IN_TIME_W-1:0]   current_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [nbrexp_pkg::STATUS_W-1:0]    status,
    output logic                               found,
    output logic [nbrexp_pkg::OUT_TIME_W-1:0]  remaining_time,
    output logic [nbrexp_pkg::COUNT_W-1:0]     live_count,
    output nbrexp_pkg::alu_op_t                alu_op,
    output logic [TIME_BITS-1:0]               alu_a,
    output logic [TIME_BITS-1:0]               alu_b,
    input  logic [TIME_BITS-1:0]               alu_res,
    input  logic                               alu_carry,
    output logic [$clog2(TABLE_DEPTH)-1:0]     rd_idx,
    input  logic [nbrexp_pkg::ADDR_W-1:0]      rd_address,
    input  logic [TIME_BITS-1:0]               rd_expiry,
    output logic                               wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]     wr_idx,
    output logic [nbrexp_pkg::ADDR_W-1:0]      wr_address,
    output logic [TIME_BITS-1:0]               wr_expiry
);
    import nbrexp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TIME_BITS-1:0]  life_reg, life_next;
    logic [TIME_BITS-1:0]  target_reg, target_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] expired_reg, expired_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [TIME_BITS-1:0]  hit_exp_reg, hit_exp_next;
    logic [TIME_BITS-1:0]  remain_reg, remain_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]      pre_cnt_reg, pre_cnt_next;
    logic [CNT_W-1:0]      post_cnt_reg, post_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic                  found_reg, found_next;
    logic [OUT_TIME_W-1:0] remain_out_reg, remain_out_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic go;
    logic entry_valid;
    logic expired;
    logic match;
    logic is_free;

    // The result register must be free before the table is changed.
    assign go          = !out_valid_reg || !out_stall;
    assign entry_valid = valid_reg[scan_idx_reg];
    assign expired     = entry_valid && !alu_carry;
    // An update matches an expired entry too; the other requests see the purged table.
    assign match       = entry_valid && (rd_address == addr_reg) &&
                         ((op_t'(op_reg) == OP_UPDATE) || !expired);
    assign is_free     = !entry_valid || expired;

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign remaining_time = remain_out_reg;
    assign live_count     = COUNT_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SUM;
            end
            S_SUM:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (go)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        now_next        = now_reg;
        life_next       = life_reg;
        target_next     = target_reg;
        valid_next      = valid_reg;
        expired_next    = expired_reg;
        scan_idx_next   = scan_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_exp_next    = hit_exp_reg;
        remain_next     = remain_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pre_cnt_next    = pre_cnt_reg;
        post_cnt_next   = post_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        found_next      = found_reg;
        remain_out_next = remain_out_reg;
        count_next      = count_reg;

        alu_op     = ALU_SUB;
        alu_a      = rd_expiry;
        alu_b      = now_reg;
        rd_idx     = '0;
        wr_en      = 1'b0;
        wr_idx     = hit_idx_reg;
        wr_address = addr_reg;
        wr_expiry  = target_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = operation;
                    addr_next = neighbor_address;
                    now_next  = TIME_BITS'(current_time);
                    life_next = TIME_BITS'(lifetime);
                end
            end
            S_SUM:
            begin
                alu_op          = ALU_ADD;
                alu_a           = now_reg;
                alu_b           = life_reg;
                target_next     = alu_carry ? '1 : alu_res;
                expired_next    = '0;
                scan_idx_next   = '0;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
                pre_cnt_next    = '0;
                post_cnt_next   = '0;
            end
            S_SCAN:
            begin
                // Memory read data is registered, so fetch the next entry now.
                rd_idx                     = scan_idx_reg + IDX_W'(1);
                expired_next[scan_idx_reg] = expired;
                pre_cnt_next  = pre_cnt_reg + CNT_W'(entry_valid);
                post_cnt_next = post_cnt_reg + CNT_W'(entry_valid && !expired);
                if (match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                    hit_exp_next = rd_expiry;
                    remain_next  = alu_res;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            S_APPLY:
            begin
                alu_a = hit_exp_reg;
                alu_b = target_reg;
                if (go)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = STAT_OK;
                    found_next      = 1'b0;
                    remain_out_next = '0;
                    count_next      = post_cnt_reg;
                    unique case (op_t'(op_reg))
                        OP_UPDATE:
                        begin
                            if (hit_reg)
                            begin
                                found_next = 1'b1;
                                count_next = pre_cnt_reg;
                                // Only move the expiry later.
                                wr_en = !alu_carry;
                            end
                            else
                            begin
                                valid_next = valid_reg & ~expired_reg;
                                if (free_found_reg)
                                begin
                                    valid_next[free_idx_reg] = 1'b1;
                                    wr_en      = 1'b1;
                                    wr_idx     = free_idx_reg;
                                    found_next = 1'b1;
                                    count_next = post_cnt_reg + CNT_W'(1);
                                end
                                else
                                    status_next = STAT_TABLE_FULL;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            valid_next = valid_reg & ~expired_reg;
                            if (hit_reg)
                            begin
                                found_next      = 1'b1;
                                remain_out_next = OUT_TIME_W'(remain_reg);
                            end
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        OP_REMOVE:
                        begin
                            valid_next = valid_reg & ~expired_reg;
                            if (hit_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                found_next = 1'b1;
                                count_next = post_cnt_reg - CNT_W'(1);
                            end
                            else
                                status_next = STAT_NOT_FOUND;
                        end
                        default:
                            count_next = pre_cnt_reg;
                    endcase
                end
            end
            default:
            begin
                rd_idx = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        now_reg        <= now_next;
        life_reg       <= life_next;
        target_reg     <= target_next;
        expired_reg    <= expired_next;
        scan_idx_reg   <= scan_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_exp_reg    <= hit_exp_next;
        remain_reg     <= remain_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pre_cnt_reg    <= pre_cnt_next;
        post_cnt_reg   <= post_cnt_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        remain_out_reg <= remain_out_next;
        count_reg      <= count_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("live count above table depth");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg == STAT_OK))
        else $error("found set with an error status");

    a_apply_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && go) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded when request finished");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |=> (state_reg == S_SCAN && scan_idx_reg == '0))
        else $error("scan did not start at the first entry");

    a_remain_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (remain_out_reg == '0))
        else $error("remaining time on a miss");

endmodule

FILE: hdl/neighbor_expiry_table_top.sv
// Top level of the neighbor expiry table.
// Depends on nbrexp_pkg, nbrexp_alu, nbrexp_mem and nbrexp_ctrl.
//
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  operation, neighbor_address, lifetime, current_time
//  out      out_valid/ out_stall status, found, remaining_time, live_count
//
// Each request passes through the lifetime add, a scan of every entry through the single
// memory read port and subtractor, and a final step that applies the change and loads the
// result register. in_stall drops only when the block returns to idle after that, so a new
// request is not taken until the previous one has loaded its result.
// A held result delays only the final cycle of the next request.
// Reset clears all valid bits at once; no clearing pass is needed.
module neighbor_expiry_table_top #(
    parameter int TABLE_DEPTH = nbrexp_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = nbrexp_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [nbrexp_pkg::OP_W-1:0]       operation,
    input  logic [nbrexp_pkg::ADDR_W-1:0]     neighbor_address,
    input  logic [nbrexp_pkg::IN_TIME_W-1:0]  lifetime,
    input  logic [nbrexp_pkg::IN_TIME_W-1:0]  current_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nbrexp_pkg::STATUS_W-1:0]   status,
    output logic                              found,
    output logic [nbrexp_pkg::OUT_TIME_W-1:0] remaining_time,
    output logic [nbrexp_pkg::COUNT_W-1:0]    live_count
);
    import nbrexp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    alu_op_t              alu_op;
    logic [TIME_BITS-1:0] alu_a;
    logic [TIME_BITS-1:0] alu_b;
    logic [TIME_BITS-1:0] alu_res;
    logic                 alu_carry;
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_W-1:0]    rd_address;
    logic [TIME_BITS-1:0] rd_expiry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [ADDR_W-1:0]    wr_address;
    logic [TIME_BITS-1:0] wr_expiry;

    nbrexp_alu #(
        .TIME_BITS(TIME_BITS)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry)
    );

    nbrexp_mem #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_address (wr_address),
        .wr_expiry  (wr_expiry),
        .rd_idx     (rd_idx),
        .rd_address (rd_address),
        .rd_expiry  (rd_expiry)
    );

    nbrexp_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .neighbor_address (neighbor_address),
        .lifetime         (lifetime),
        .current_time     (current_time),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .found            (found),
        .remaining_time   (remaining_time),
        .live_count       (live_count),
        .alu_op           (alu_op),
        .alu_a            (alu_a),
        .alu_b            (alu_b),
        .alu_res          (alu_res),
        .alu_carry        (alu_carry),
        .rd_idx           (rd_idx),
        .rd_address       (rd_address),
        .rd_expiry        (rd_expiry),
        .wr_en            (wr_en),
        .wr_idx           (wr_idx),
        .wr_address       (wr_address),
        .wr_expiry        (wr_expiry)
    );

endmodule
